@@ rtl/iee_pkg.sv @@
// Package of the infix expression evaluator: token codes, status codes, widths.
package iee_pkg;
  localparam int unsigned ValueWidth = 48;
  localparam int unsigned CmdWidth = 3;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned DefStackDepth = 64;
  localparam int unsigned DefFracBits = 16;

  typedef enum logic [CmdWidth-1:0] {
    CmdNum = 3'd0, CmdAdd = 3'd1, CmdSub = 3'd2, CmdMul = 3'd3,
    CmdDiv = 3'd4, CmdOpen = 3'd5, CmdClose = 3'd6, CmdEnd = 3'd7
  } cmd_e;

  typedef enum logic [StatusWidth-1:0] {
    StOk = 2'd0, StDivZero = 2'd1, StOverflow = 2'd2, StMalformed = 2'd3
  } status_e;

  typedef struct packed {
    logic start;
    cmd_e op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;
endpackage

@@ rtl/infix_expression_evaluator.sv @@
// Top level of the infix expression evaluator: token sequencer, stacks and result register.
//  channel | direction | handshake          | payload
//  token   | in        | in_valid_i/ready_o | cmd_i, token_value_i
//  result  | out       | out_valid_o/ready_i| value_o, status_o
// A token holds the sequencer from its acceptance until the sequencer is idle again,
// with extra steps when a product is implied and for end. Each operator applied runs
// in the one shared arithmetic unit, whether add, subtract, multiply or divide.
// Reset empties both stacks.
// An end request waits in its last cycle while the previous result is still held.
module infix_expression_evaluator #(
  parameter int unsigned StackDepth = iee_pkg::DefStackDepth,
  parameter int unsigned FracBits = iee_pkg::DefFracBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [iee_pkg::CmdWidth-1:0] cmd_i,
  input  logic signed [iee_pkg::ValueWidth-1:0] token_value_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic signed [iee_pkg::ValueWidth-1:0] value_o,
  output logic [iee_pkg::StatusWidth-1:0] status_o
);
  import iee_pkg::*;
  localparam int unsigned W = ValueWidth;
  localparam int unsigned AW = $clog2(StackDepth);
  localparam int unsigned CW = $clog2(StackDepth + 1);

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SDispatch = 4'd1;
  localparam logic [3:0] SPopOp = 4'd2;
  localparam logic [3:0] SRdA = 4'd3;
  localparam logic [3:0] SRdB = 4'd4;
  localparam logic [3:0] SAlu = 4'd5;
  localparam logic [3:0] SAluWait = 4'd6;
  localparam logic [3:0] SFinish = 4'd7;
  localparam logic [3:0] SRdRes = 4'd8;
  localparam logic [3:0] SResult = 4'd9;
  localparam logic [3:0] SOpRd = 4'd10;

  logic signed [W-1:0] opnd_mem [StackDepth];
  logic [CmdWidth-1:0] oper_mem [StackDepth];

  logic [3:0] state_q, state_d;
  logic [CW-1:0] ocnt_q, ocnt_d, pcnt_q, pcnt_d;
  logic prev_q, prev_d;
  logic [StatusWidth-1:0] err_q, err_d;
  cmd_e cmd_q, cmd_d;
  logic signed [W-1:0] tok_q, tok_d;
  logic mulpend_q, mulpend_d;
  logic [CmdWidth-1:0] top_q, oprd_q;
  logic signed [W-1:0] a_q, b_q, rd_q;
  logic signed [W-1:0] val_q, val_d;
  logic [StatusWidth-1:0] st_q, st_d;
  logic outv_q, outv_d;

  logic o_we, p_we;
  logic [AW-1:0] o_wa, p_wa, o_ra, p_ra;
  logic signed [W-1:0] o_wd;
  logic [CmdWidth-1:0] p_wd;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  logic signed [W-1:0] alu_res;
  cmd_e pending;

  function automatic logic [1:0] prec(logic [CmdWidth-1:0] op);
    if (op == CmdAdd || op == CmdSub) return 2'd1;
    if (op == CmdMul || op == CmdDiv) return 2'd2;
    return 2'd0;
  endfunction

  iee_alu #(.FracBits(FracBits)) u_alu (
    .clk_i, .rst_ni, .req_i(alu_req), .a_i(a_q), .b_i(b_q), .rsp_o(alu_rsp), .res_o(alu_res)
  );

  assign pending = mulpend_q ? CmdMul : cmd_q;
  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    state_d = state_q; ocnt_d = ocnt_q; pcnt_d = pcnt_q; prev_d = prev_q;
    err_d = err_q; cmd_d = cmd_q; tok_d = tok_q; mulpend_d = mulpend_q;
    val_d = val_q; st_d = st_q; outv_d = outv_q;
    o_we = 1'b0; p_we = 1'b0; o_wd = alu_res; p_wd = cmd_q;
    o_wa = AW'(ocnt_q - 1'b1); p_wa = pcnt_q[AW-1:0];
    o_ra = AW'(ocnt_q - 1'b1); p_ra = AW'(pcnt_q - 1'b1);
    alu_req.start = 1'b0; alu_req.op = cmd_e'(top_q);
    if (outv_q && out_ready_i) outv_d = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_d = cmd_e'(cmd_i); tok_d = token_value_i;
          mulpend_d = (cmd_i == CmdNum || cmd_i == CmdOpen) && prev_q;
          state_d = SOpRd;
          if (cmd_i != CmdEnd && err_q != StOk) state_d = SIdle;
        end
      end
      SOpRd: state_d = SDispatch;
      SDispatch: begin
        if (err_q != StOk) begin
          state_d = (cmd_q == CmdEnd) ? SFinish : SIdle;
        end else if (cmd_q == CmdEnd) begin
          if (pcnt_q == '0) state_d = SFinish;
          else if (top_q == CmdOpen) begin
            err_d = StMalformed; state_d = SFinish;
          end else state_d = SPopOp;
        end else if (cmd_q == CmdClose) begin
          if (pcnt_q == '0) begin
            err_d = StMalformed; prev_d = 1'b1; state_d = SIdle;
          end else if (top_q == CmdOpen) begin
            pcnt_d = pcnt_q - 1'b1; prev_d = 1'b1; state_d = SIdle;
          end else state_d = SPopOp;
        end else if (pending != CmdNum && pending != CmdOpen && pcnt_q != '0 &&
                     top_q != CmdOpen && prec(top_q) >= prec(pending)) begin
          state_d = SPopOp;
        end else if (mulpend_q) begin
          if (pcnt_q == CW'(StackDepth)) begin
            err_d = StOverflow; state_d = SIdle;
          end else begin
            p_we = 1'b1; p_wd = CmdMul; pcnt_d = pcnt_q + 1'b1;
            mulpend_d = 1'b0; state_d = SOpRd;
          end
        end else if (cmd_q == CmdNum) begin
          if (ocnt_q == CW'(StackDepth)) err_d = StOverflow;
          else begin
            o_we = 1'b1; o_wa = ocnt_q[AW-1:0]; o_wd = tok_q;
            ocnt_d = ocnt_q + 1'b1; prev_d = 1'b1;
          end
          state_d = SIdle;
        end else begin
          if (pcnt_q == CW'(StackDepth)) err_d = StOverflow;
          else begin
            p_we = 1'b1; pcnt_d = pcnt_q + 1'b1; prev_d = 1'b0;
          end
          state_d = SIdle;
        end
      end
      SPopOp: begin
        pcnt_d = pcnt_q - 1'b1;
        if (ocnt_q < CW'(2)) begin
          err_d = StMalformed;
          state_d = (cmd_q == CmdEnd) ? SFinish : SIdle;
          if (cmd_q == CmdClose) prev_d = 1'b1;
          else if (cmd_q != CmdEnd) prev_d = 1'b0;
        end else state_d = SRdB;
      end
      SRdB: begin
        o_ra = AW'(ocnt_q - 2'd2); state_d = SRdA;
      end
      SRdA: state_d = SAlu;
      SAlu: begin
        alu_req.start = 1'b1; state_d = SAluWait;
      end
      SAluWait: begin
        if (alu_rsp.done) begin
          if (alu_rsp.div_zero) begin
            err_d = StDivZero;
            state_d = (cmd_q == CmdEnd) ? SFinish : SIdle;
            if (cmd_q == CmdClose) prev_d = 1'b1;
            else if (cmd_q != CmdEnd) prev_d = 1'b0;
          end else begin
            o_we = 1'b1; o_wa = AW'(ocnt_q - 2'd2); ocnt_d = ocnt_q - 1'b1;
            state_d = SOpRd;
          end
        end
      end
      SFinish: begin
        if (err_q == StOk && ocnt_q != CW'(1)) err_d = StMalformed;
        o_ra = '0; state_d = SRdRes;
      end
      SRdRes: state_d = SResult;
      SResult: begin
        if (!outv_q || out_ready_i) begin
          st_d = err_q; val_d = (err_q == StOk) ? rd_q : '0; outv_d = 1'b1;
          ocnt_d = '0; pcnt_d = '0; prev_d = 1'b0; err_d = StOk; state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (o_we) opnd_mem[o_wa] <= o_wd;
    if (p_we) oper_mem[p_wa] <= p_wd;
    rd_q <= opnd_mem[o_ra];
    oprd_q <= oper_mem[p_ra];
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; tok_q <= tok_d; val_q <= val_d; st_q <= st_d;
    if (state_q == SDispatch) top_q <= oprd_q;
    if (state_q == SOpRd) top_q <= oprd_q;
    if (state_q == SRdB) b_q <= rd_q;
    if (state_q == SRdA) a_q <= rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; ocnt_q <= '0; pcnt_q <= '0; prev_q <= 1'b0;
      err_q <= StOk; mulpend_q <= 1'b0; outv_q <= 1'b0;
    end else begin
      state_q <= state_d; ocnt_q <= ocnt_d; pcnt_q <= pcnt_d; prev_q <= prev_d;
      err_q <= err_d; mulpend_q <= mulpend_d; outv_q <= outv_d;
    end
  end

  assign out_valid_o = outv_q;
  assign value_o = val_q;
  assign status_o = st_q;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= CW'(StackDepth) && pcnt_q <= CW'(StackDepth)) else $error("stack count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SResult && (!out_valid_o || out_ready_i))
    |=> out_valid_o && ocnt_q == '0 && pcnt_q == '0)
    else $error("stacks not emptied");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StOk) |-> value_o == '0) else $error("value on error");
`endif
endmodule

@@ rtl/iee_alu.sv @@
// Shared fixed-point arithmetic unit: saturating add and subtract, multiply, divide.
module iee_alu #(
  parameter int unsigned FracBits = iee_pkg::DefFracBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  iee_pkg::alu_req_t req_i,
  input  logic signed [iee_pkg::ValueWidth-1:0] a_i,
  input  logic signed [iee_pkg::ValueWidth-1:0] b_i,
  output iee_pkg::alu_rsp_t rsp_o,
  output logic signed [iee_pkg::ValueWidth-1:0] res_o
);
  import iee_pkg::*;
  localparam int unsigned W = ValueWidth;
  localparam int unsigned NW = W + FracBits;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned CW = $clog2(NW + 1);
  localparam logic [PW-1:0] MagPos = PW'({1'b0, {(W-1){1'b1}}});
  localparam logic [PW-1:0] MagNeg = PW'({1'b1, {(W-1){1'b0}}});

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SMul = 3'd1;
  localparam logic [2:0] SDiv = 3'd2;
  localparam logic [2:0] SPack = 3'd3;
  localparam logic [2:0] SDone = 3'd4;

  logic [2:0] state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] acc_q, acc_d;
  logic [NW-1:0] num_q, num_d;
  logic [W:0] rem_q, rem_d;
  logic [W-1:0] ma_q, ma_d, mb_q, mb_d;
  logic neg_q, neg_d;
  logic signed [W-1:0] res_q, res_d;
  logic dz_q, dz_d;

  logic [W-1:0] mag_a, mag_b;
  logic signed [W:0] sum;
  logic [W:0] rsh;

  assign mag_a = a_i[W-1] ? W'(-a_i) : W'(a_i);
  assign mag_b = b_i[W-1] ? W'(-b_i) : W'(b_i);
  assign sum = (req_i.op == CmdSub) ? ((W+1)'(a_i) - (W+1)'(b_i))
                                    : ((W+1)'(a_i) + (W+1)'(b_i));
  assign rsh = {rem_q[W-1:0], num_q[NW-1]};

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; acc_d = acc_q; num_d = num_q;
    rem_d = rem_q; ma_d = ma_q; mb_d = mb_q; neg_d = neg_q;
    res_d = res_q; dz_d = dz_q;
    unique case (state_q)
      SIdle: begin
        if (req_i.start) begin
          neg_d = a_i[W-1] ^ b_i[W-1];
          ma_d = mag_a; mb_d = mag_b; dz_d = 1'b0; cnt_d = '0;
          acc_d = '0; rem_d = '0;
          num_d = NW'(mag_a) << FracBits;
          unique case (req_i.op)
            CmdMul: state_d = SMul;
            CmdDiv: begin
              if (b_i == '0) begin
                dz_d = 1'b1; state_d = SDone;
              end else begin
                state_d = SDiv;
              end
            end
            default: begin
              if (sum[W] != sum[W-1]) res_d = sum[W] ? {1'b1, {(W-1){1'b0}}}
                                                     : {1'b0, {(W-1){1'b1}}};
              else res_d = sum[W-1:0];
              state_d = SDone;
            end
          endcase
        end
      end
      SMul: begin
        if (mb_q[cnt_q[$clog2(W)-1:0]]) acc_d = acc_q + (PW'(ma_q) << cnt_q);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          acc_d = (mb_q[cnt_q[$clog2(W)-1:0]] ? acc_q + (PW'(ma_q) << cnt_q) : acc_q)
                  >> FracBits;
          state_d = SPack;
        end
      end
      SDiv: begin
        num_d = num_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (rsh >= {1'b0, mb_q}) begin
          rem_d = rsh - {1'b0, mb_q};
          acc_d = {acc_q[PW-2:0], 1'b1};
        end else begin
          rem_d = rsh;
          acc_d = {acc_q[PW-2:0], 1'b0};
        end
        if (cnt_q == CW'(NW - 1)) state_d = SPack;
      end
      SPack: begin
        if (neg_q) res_d = (acc_q > MagNeg) ? {1'b1, {(W-1){1'b0}}} : W'(-acc_q[W-1:0]);
        else res_d = (acc_q > MagPos) ? {1'b0, {(W-1){1'b1}}} : acc_q[W-1:0];
        state_d = SDone;
      end
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; num_q <= num_d; rem_q <= rem_d; ma_q <= ma_d;
    mb_q <= mb_d; neg_q <= neg_d; res_q <= res_d; dz_q <= dz_d;
  end

  assign rsp_o.done = (state_q == SDone);
  assign rsp_o.div_zero = dz_q;
  assign res_o = res_q;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |=> state_q == SIdle) else $error("done not followed by idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SPack) |=> rsp_o.done) else $error("pack not followed by done");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDiv) |-> !dz_q) else $error("dividing by zero");
`endif
endmodule
